@@ rtl/fpalu_pkg.sv @@
// shared action codes and widths for the fixed-point alu
package fpalu_pkg;

  localparam int ActionWidth = 4;
  localparam int ValueWidth  = 32;
  localparam int DivSteps    = 4;

  localparam logic [ActionWidth-1:0] ACT_ADD  = 4'd0;
  localparam logic [ActionWidth-1:0] ACT_SUB  = 4'd1;
  localparam logic [ActionWidth-1:0] ACT_MUL  = 4'd2;
  localparam logic [ActionWidth-1:0] ACT_DIV  = 4'd3;
  localparam logic [ActionWidth-1:0] ACT_MIN  = 4'd4;
  localparam logic [ActionWidth-1:0] ACT_MAX  = 4'd5;
  localparam logic [ActionWidth-1:0] ACT_INC  = 4'd6;
  localparam logic [ActionWidth-1:0] ACT_DEC  = 4'd7;
  localparam logic [ActionWidth-1:0] ACT_ITOF = 4'd8;
  localparam logic [ActionWidth-1:0] ACT_FTOI = 4'd9;

endpackage

@@ rtl/fixed_point_q24_8_alu_core.sv @@
// signed fixed-point alu: add, sub, mul, div, min, max, steps and conversions
//
// usage:
//   s_axis carries one operation per beat: action, operand_a, operand_b.
//   m_axis returns one beat per operation with the raw result and flags
//   (signed compare of a against b, saturation, zero divisor).
//   all operations share one pipeline so results leave in input order.
// pipeline:
//   an entry register, the restoring divider stages and the output register
//   lie between accept and result valid; each divider stage resolves up to
//   four quotient bits. the multiplier sits in the first divider stage,
//   rounding and saturation in the output stage.
// throughput:
//   one beat per cycle while the output does not stall.
// reset:
//   all valid bits clear, the output is empty and s_axis_tready is high.
// stall:
//   while m_axis_tready is low with a result waiting, the whole pipeline
//   holds and s_axis_tready drops; nothing is lost or repeated.
module fixed_point_q24_8_alu_core
  import fpalu_pkg::*;
#(
  parameter int FRACTION_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // action[3:0], operand_a[35:4], operand_b[67:36], zero fill
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_value[31:0], a_less, a_equal, a_greater, overflow, divide_by_zero, zero fill
  output logic [39:0] m_axis_tdata
);

  localparam int DW = 33 + FRACTION_BITS;
  localparam int DS = (DW + DivSteps - 1) / DivSteps;

  typedef struct packed {
    logic [ActionWidth-1:0] action;
    logic                   neg;
    logic                   den_zero;
    logic [ValueWidth-1:0]  simple;
    logic                   lt;
    logic                   eq;
    logic                   gt;
    logic [63:0]            prod;
    logic [ValueWidth-1:0]  den;
    logic [ValueWidth:0]    rem;
    logic [DW-1:0]          qd;
  } pipe_t;

  pipe_t           pipe_q [DS+1];
  pipe_t           pipe_d [DS+1];
  logic [DS:0]     valid_q;
  logic            out_valid_q;
  logic [39:0]     out_data_q;
  logic [39:0]     out_data_d;
  logic            adv;

  logic [ActionWidth-1:0] in_act;
  logic [ValueWidth-1:0]  in_a;
  logic [ValueWidth-1:0]  in_b;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign in_act        = s_axis_tdata[3:0];
  assign in_a          = s_axis_tdata[35:4];
  assign in_b          = s_axis_tdata[67:36];

  // entry stage: compares, simple ops, magnitudes
  always_comb begin
    logic [ValueWidth-1:0] mag_a;
    logic [ValueWidth-1:0] mag_b;
    logic lt;
    logic gt;
    lt = $signed(in_a) < $signed(in_b);
    gt = $signed(in_a) > $signed(in_b);
    mag_a = in_a[ValueWidth-1] ? (~in_a + 1'b1) : in_a;
    mag_b = in_b[ValueWidth-1] ? (~in_b + 1'b1) : in_b;
    pipe_d[0].action   = in_act;
    pipe_d[0].neg      = in_a[ValueWidth-1] ^ in_b[ValueWidth-1];
    pipe_d[0].den_zero = (in_b == '0);
    pipe_d[0].lt       = lt;
    pipe_d[0].eq       = (in_a == in_b);
    pipe_d[0].gt       = gt;
    pipe_d[0].prod     = '0;
    pipe_d[0].den      = mag_b;
    pipe_d[0].rem      = '0;
    pipe_d[0].qd       = {mag_a, {(FRACTION_BITS + 1){1'b0}}};
    case (in_act)
      ACT_ADD:  pipe_d[0].simple = in_a + in_b;
      ACT_SUB:  pipe_d[0].simple = in_a - in_b;
      ACT_MIN:  pipe_d[0].simple = lt ? in_a : in_b;
      ACT_MAX:  pipe_d[0].simple = gt ? in_a : in_b;
      ACT_INC:  pipe_d[0].simple = in_a + 1'b1;
      ACT_DEC:  pipe_d[0].simple = in_a - 1'b1;
      ACT_ITOF: pipe_d[0].simple = in_a << FRACTION_BITS;
      ACT_FTOI: pipe_d[0].simple = ValueWidth'($signed(in_a) >>> FRACTION_BITS);
      default:  pipe_d[0].simple = '0;
    endcase
  end

  // divider stages, up to four restoring steps each; multiply in the first
  for (genvar k = 0; k < DS; k++) begin : g_div
    always_comb begin
      logic [ValueWidth:0] r;
      logic [ValueWidth:0] t;
      logic [DW-1:0]       x;
      r = pipe_q[k].rem;
      x = pipe_q[k].qd;
      t = '0;
      pipe_d[k+1] = pipe_q[k];
      for (int j = 0; j < DivSteps; j++) begin
        if (k * DivSteps + j < DW) begin
          t = {r[ValueWidth-1:0], x[DW-1]};
          x = {x[DW-2:0], 1'b0};
          if (t >= {1'b0, pipe_q[k].den}) begin
            t    = t - {1'b0, pipe_q[k].den};
            x[0] = 1'b1;
          end
          r = t;
        end
      end
      pipe_d[k+1].rem = r;
      pipe_d[k+1].qd  = x;
      if (k == 0) begin
        pipe_d[k+1].prod = 64'(pipe_q[k].qd[DW-1 -: ValueWidth]) * 64'(pipe_q[k].den);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[DS-1:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k <= DS; k++) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  // output stage: rounding, saturation, result select
  always_comb begin
    pipe_t       p;
    logic [DW:0] qdiv;
    logic [63:0] mag;
    logic [63:0] lim;
    logic [ValueWidth-1:0] res;
    logic sat;
    logic dbz;
    logic ovf;
    p    = pipe_q[DS];
    qdiv = ({1'b0, p.qd} + 1'b1) >> 1;
    if (p.action == ACT_MUL) begin
      mag = (p.prod + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
    end else begin
      mag = 64'(qdiv);
    end
    lim = p.neg ? 64'h8000_0000 : 64'h7fff_ffff;
    sat = 1'b0;
    dbz = 1'b0;
    // saturation compares the unclamped magnitude against the limit
    ovf = (mag > lim);
    if (ovf) begin
      mag = lim;
    end
    case (p.action)
      ACT_MUL, ACT_DIV: begin
        if (p.action == ACT_DIV && p.den_zero) begin
          dbz = 1'b1;
          res = '0;
        end else begin
          sat = ovf;
          res = p.neg ? (~mag[ValueWidth-1:0] + 1'b1) : mag[ValueWidth-1:0];
        end
      end
      default: res = p.simple;
    endcase
    out_data_d = {3'b000, dbz, sat, p.gt, p.eq, p.lt, res};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= valid_q[DS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_cmp_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot(m_axis_tdata[34:32]))
    else $error("compare flags not one-hot");

  a_dbz_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[36]) |-> (!m_axis_tdata[35] && m_axis_tdata[31:0] == '0))
    else $error("zero divisor result not clean");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready does not follow output register");

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the q24.8 fixed-point alu stream core
`timescale 1ns / 1ps

module testbench
  import fpalu_pkg::*;
;

  localparam int FracBits = 8;
  localparam int RandomOps = 2000;
  localparam int Latency = (33 + FracBits + 3) / 4 + 2;

  typedef struct packed {
    logic        divide_by_zero;
    logic        overflow;
    logic        a_greater;
    logic        a_equal;
    logic        a_less;
    logic [31:0] result_value;
  } alu_result_t;

  typedef struct {
    logic [3:0]  action;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    bit          has_fixed;
    logic [31:0] fixed_value;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;

  alu_result_t pending_results[$];
  int          mismatch_count;
  bit          hold_off;

  fixed_point_q24_8_alu_core #(.FRACTION_BITS(FracBits)) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // saturate a signed magnitude into 32 bits
  function automatic logic [31:0] clamp32(logic [63:0] mag, bit neg, ref bit sat);
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        sat = 1'b1;
        mag = 64'h8000_0000;
      end
      return 32'(-mag);
    end
    if (mag > 64'h7fff_ffff) begin
      sat = 1'b1;
      mag = 64'h7fff_ffff;
    end
    return mag[31:0];
  endfunction

  function automatic alu_result_t alu_predict(logic [3:0] act, logic [31:0] ua,
                                              logic [31:0] ub);
    alu_result_t r;
    logic signed [31:0] sa;
    logic signed [31:0] sb;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] q;
    bit sat;
    sa = ua;
    sb = ub;
    ma = sa < 0 ? 64'(-64'(sa)) : 64'(sa);
    mb = sb < 0 ? 64'(-64'(sb)) : 64'(sb);
    sat = 1'b0;
    r = '0;
    case (act)
      ACT_ADD: r.result_value = ua + ub;
      ACT_SUB: r.result_value = ua - ub;
      ACT_MUL: begin
        q = (ma * mb + (64'd1 << (FracBits - 1))) >> FracBits;
        r.result_value = clamp32(q, (sa < 0) != (sb < 0), sat);
      end
      ACT_DIV: begin
        if (sb == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          q = (2 * (ma << FracBits) + mb) / (2 * mb);
          r.result_value = clamp32(q, (sa < 0) != (sb < 0), sat);
        end
      end
      ACT_MIN: r.result_value = (sa < sb) ? ua : ub;
      ACT_MAX: r.result_value = (sa > sb) ? ua : ub;
      ACT_INC: r.result_value = ua + 1;
      ACT_DEC: r.result_value = ua - 1;
      ACT_ITOF: r.result_value = ua << FracBits;
      ACT_FTOI: r.result_value = sa >>> FracBits;
      default: r.result_value = '0;
    endcase
    r.overflow = sat;
    r.a_less = sa < sb;
    r.a_equal = sa == sb;
    r.a_greater = sa > sb;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  task automatic send_op(logic [3:0] act, logic [31:0] a, logic [31:0] b,
                         bit has_fixed, logic [31:0] fixed_value);
    alu_result_t exp_res;
    int gap;
    exp_res = alu_predict(act, a, b);
    if (has_fixed && exp_res.result_value !== fixed_value)
      report_mismatch("predictor vs table", exp_res.result_value, fixed_value);
    if (has_fixed) exp_res.result_value = fixed_value;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, b, a, act};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(exp_res);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(0, 1024)) - 32'd512;
      3: return $urandom_range(0, 3) - 1;
      4: return 32'($signed($urandom)) >>> $urandom_range(0, 24);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    stim_row_t rows[$];
    logic [31:0] a;
    logic [31:0] b;
    logic [3:0] act;
    rows.push_back('{ACT_ADD, 32'h7fff_ffff, 32'd1, 1, 32'h8000_0000});
    rows.push_back('{ACT_SUB, 32'h8000_0000, 32'd1, 1, 32'h7fff_ffff});
    rows.push_back('{ACT_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 1, 32'h7fff_ffff});
    rows.push_back('{ACT_MUL, 32'h8000_0000, 32'h7fff_ffff, 1, 32'h8000_0000});
    rows.push_back('{ACT_MUL, 32'h8000_0000, 32'h8000_0000, 1, 32'h7fff_ffff});
    rows.push_back('{ACT_MUL, 32'h0000_0180, 32'hffff_fe80, 0, 0});
    rows.push_back('{ACT_MUL, 32'd1, 32'h80, 0, 0});
    rows.push_back('{ACT_MUL, 32'hffff_ffff, 32'h80, 0, 0});
    rows.push_back('{ACT_DIV, 32'h7fff_ffff, 32'd0, 1, 32'd0});
    rows.push_back('{ACT_DIV, 32'h8000_0000, 32'd0, 1, 32'd0});
    rows.push_back('{ACT_DIV, 32'h8000_0000, 32'd1, 1, 32'h8000_0000});
    rows.push_back('{ACT_DIV, 32'h7fff_ffff, 32'hffff_ffff, 1, 32'h8000_0000});
    rows.push_back('{ACT_DIV, 32'h100, 32'h300, 0, 0});
    rows.push_back('{ACT_DIV, 32'hffff_ff00, 32'h200, 0, 0});
    rows.push_back('{ACT_MIN, 32'h8000_0000, 32'h7fff_ffff, 1, 32'h8000_0000});
    rows.push_back('{ACT_MAX, 32'h8000_0000, 32'h7fff_ffff, 1, 32'h7fff_ffff});
    rows.push_back('{ACT_INC, 32'h7fff_ffff, 32'd0, 1, 32'h8000_0000});
    rows.push_back('{ACT_DEC, 32'h8000_0000, 32'd0, 1, 32'h7fff_ffff});
    rows.push_back('{ACT_ITOF, 32'h0080_0000, 32'd0, 1, 32'h8000_0000});
    rows.push_back('{ACT_ITOF, 32'hffff_ffff, 32'd0, 1, 32'hffff_ff00});
    rows.push_back('{ACT_FTOI, 32'hffff_ff01, 32'd0, 1, 32'hffff_ffff});
    rows.push_back('{ACT_FTOI, 32'h8000_0000, 32'd0, 1, 32'hff80_0000});
    rows.push_back('{4'd10, 32'd5, 32'd5, 1, 32'd0});
    rows.push_back('{4'd15, 32'hffff_ffff, 32'hffff_ffff, 1, 32'd0});

    mismatch_count = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (rows[i])
      send_op(rows[i].action, rows[i].operand_a, rows[i].operand_b,
              rows[i].has_fixed, rows[i].fixed_value);
    for (int n = 0; n < RandomOps; n++) begin
      act = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                          : 4'($urandom_range(0, 9));
      a = rand_operand();
      b = ($urandom_range(0, 4) == 0) ? a : rand_operand();
      send_op(act, a, b, 0, 0);
    end
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // long receiver hold-off so the pipeline fills and back-pressures
  initial begin
    hold_off = 1'b0;
    wait (rst_ni);
    repeat (300) @(negedge clk_i);
    hold_off = 1'b1;
    repeat (80) @(negedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) m_axis_tready <= 1'b0;
      else if ($urandom_range(0, 3) == 0) m_axis_tready <= 1'b1;
      else if ($urandom_range(0, 29) == 0) m_axis_tready <= 1'b0;
      else m_axis_tready <= ($urandom_range(0, 4) != 0);
    end
  end

  always @(posedge clk_i) begin
    alu_result_t got;
    alu_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[36:0];
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", got.result_value, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.result_value !== want.result_value)
          report_mismatch("result_value", got.result_value, want.result_value);
        if (got.a_less !== want.a_less)
          report_mismatch("a_less", 32'(got.a_less), 32'(want.a_less));
        if (got.a_equal !== want.a_equal)
          report_mismatch("a_equal", 32'(got.a_equal), 32'(want.a_equal));
        if (got.a_greater !== want.a_greater)
          report_mismatch("a_greater", 32'(got.a_greater), 32'(want.a_greater));
        if (got.overflow !== want.overflow)
          report_mismatch("overflow", 32'(got.overflow), 32'(want.overflow));
        if (got.divide_by_zero !== want.divide_by_zero)
          report_mismatch("divide_by_zero", 32'(got.divide_by_zero),
                          32'(want.divide_by_zero));
      end
    end
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ fixed_point_q24_8_alu_core.f @@
rtl/fpalu_pkg.sv
rtl/fixed_point_q24_8_alu_core.sv
tb/testbench.sv
